// ===== sv/sdkt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdkt_pkg
// Shared types and codes for the sorted descending key table.
// ----------------------------------------------------------------------------
package sdkt_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // per-cycle strobes broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } op_t;

    // compare flags a cell reports for its held key
    typedef struct packed {
        logic ins_ge;   // cell lies at or past the insert point
        logic del_ge;   // cell lies at or past the first occurrence of the key
        logic eq;       // cell holds the key
    } flags_t;

endpackage

// ===== sv/sdkt_cell.sv =====
// ----------------------------------------------------------------------------
// sdkt_cell
// One slot of the table: holds a key, compares it against the broadcast key
// and shifts toward its right or left neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sdkt_cell (
    input  logic            aclk,
    input  sdkt_pkg::op_t   op,
    input  sdkt_pkg::key_t  cmp_key,
    input  logic            occupied,
    input  sdkt_pkg::key_t  left_key,
    input  logic            left_ins_ge,
    input  sdkt_pkg::key_t  right_key,
    output sdkt_pkg::key_t  key_out,
    output sdkt_pkg::flags_t flags
);
    import sdkt_pkg::*;

    key_t key_reg;
    key_t key_next;

    always_comb begin
        flags.ins_ge = !occupied || (key_reg < cmp_key);
        flags.del_ge = occupied && (key_reg <= cmp_key);
        flags.eq     = occupied && (key_reg == cmp_key);
    end

    always_comb begin
        key_next = key_reg;
        if (op.ins_en) begin
            if (left_ins_ge) begin
                key_next = left_key;
            end else if (flags.ins_ge) begin
                key_next = cmp_key;
            end
        end else if (op.del_en && flags.del_ge) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

// ===== sv/sorted_descending_key_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_descending_key_table_top
// Sorted descending key table: insert or delete one key per word.
// Latency: result word is valid the cycle after the input word is accepted.
// Throughput: one word per cycle unless the result channel stalls; every cell
// compares and shifts in parallel, updating the whole chain for each word.
// Reset: aresetn clears the count and output valid; cell keys are not reset.
// ----------------------------------------------------------------------------
module sorted_descending_key_table_top #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  sdkt_pkg::key_t      s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output sdkt_pkg::status_t   m_status,
    output logic [4:0]          m_count
);
    import sdkt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [4:0]       m_count_reg;
    status_t          status_next;

    logic    accept;
    logic    full;
    logic    empty;
    logic    found;
    op_t     op;

    key_t    cell_key [CAPACITY];
    flags_t  cell_flags [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign found   = |eq_vec;

    always_comb begin
        op.ins_en = accept && (s_command == CMD_INSERT) && !full;
        op.del_en = accept && (s_command == CMD_DELETE) && found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            key_t left_key;
            logic left_ge;
            key_t right_key;

            if (gi == 0) begin : g_first
                assign left_key = s_key;
                assign left_ge  = 1'b0;
            end else begin : g_mid
                assign left_key = cell_key[gi-1];
                assign left_ge  = cell_flags[gi-1].ins_ge;
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_key = cell_key[gi];
            end else begin : g_inner
                assign right_key = cell_key[gi+1];
            end

            sdkt_cell u_cell (
                .aclk        (aclk),
                .op          (op),
                .cmp_key     (s_key),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_key    (left_key),
                .left_ins_ge (left_ge),
                .right_key   (right_key),
                .key_out     (cell_key[gi]),
                .flags       (cell_flags[gi])
            );

            assign eq_vec[gi] = cell_flags[gi].eq;
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (s_command == CMD_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            priority if (empty) begin
                status_next = ST_EMPTY;
            end else if (!found) begin
                status_next = ST_MISSING;
            end else begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= status_next;
            m_count_reg  <= 5'(count_next);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    // count stays within the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    // count moves only when a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count changed without an accepted word");

    // insert into a full table reports full and keeps the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_INSERT && full)
            |=> (m_status == ST_FULL && $stable(count_reg)))
        else $error("full insert handled wrongly");

    // a pending result always reflects the current count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count == 5'(count_reg)))
        else $error("result count out of step with table");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_descending_key_table_top: a directed table of insert
// and delete words, then random fill, drain and mixed phases. Every result
// word is checked against typed directed rows or an in-bench table predictor,
// with bursty input traffic and a patterned stall on the result channel.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdkt_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_WORDS = 650;
    localparam int PHASE_LEN = 50;

    typedef struct {
        status_t    status;
        logic [4:0] count;
    } result_t;

    typedef struct {
        logic       cmd;
        key_t       k;
        bit         typed;
        status_t    status;
        logic [4:0] count;
    } stim_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = CMD_INSERT;
    key_t       s_key = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    status_t    m_status;
    logic [4:0] m_count;

    // predictor copy of the table
    key_t       held_keys [DEPTH];
    int         held_cnt = 0;

    result_t    pending_results [$];
    int         errors = 0;
    int         burst_left = 0;

    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_span = 0;
    int         rx_phase = 0;

    stim_row_t  directed_rows [25];

    sorted_descending_key_table_top #(.CAPACITY(DEPTH)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_key     (s_key),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_count   (m_count)
    );

    always #6 aclk = ~aclk;

    // apply one word to the predicted table, return its result
    function automatic result_t table_apply(input logic cmd, input key_t k);
        result_t r;
        int pos;
        pos = 0;
        r.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (held_cnt >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new key lands after any equal keys
                while (pos < held_cnt && !(held_keys[pos] < k)) pos++;
                for (int i = held_cnt; i > pos; i--) held_keys[i] = held_keys[i-1];
                held_keys[pos] = k;
                held_cnt++;
            end
        end else begin
            if (held_cnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                while (pos < held_cnt && held_keys[pos] != k) pos++;
                if (pos >= held_cnt) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int i = pos; i + 1 < held_cnt; i++) held_keys[i] = held_keys[i+1];
                    held_cnt--;
                end
            end
        end
        r.count = 5'(held_cnt);
        return r;
    endfunction

    function automatic key_t random_key();
        key_t k;
        case ($urandom_range(0, 9))
            0: k = 32'h7FFF_FFFF;
            1: k = 32'h8000_0000;
            2, 3, 4: k = key_t'($urandom_range(0, 6)) - key_t'(3);
            default: k = key_t'($urandom);
        endcase
        return k;
    endfunction

    task automatic send_word(input logic cmd, input key_t k, input bit typed,
                             input result_t typed_res);
        result_t pred;
        int gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = table_apply(cmd, k);
        pending_results.push_back(typed ? typed_res : pred);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid   <= 1'b0;
                s_command <= 1'($urandom_range(0, 1));
                s_key     <= key_t'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // result channel stall pattern
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(16, 80);
        end else begin
            rx_span <= rx_span - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (rx_phase % 5 != 0);
        endcase
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t tb: result word with none expected, status %0d count %0d",
                         $time, m_status, m_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t tb: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_count !== want.count) begin
                    $display("%0t tb: count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        result_t typed_res;
        key_t    k;
        logic    cmd;
        int      ins_pct;

        directed_rows = '{
            '{CMD_DELETE, 32'h0000_0000, 1'b1, ST_EMPTY,   5'd0},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ST_OK,      5'd1},
            '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_OK,      5'd2},
            '{CMD_INSERT, 32'h0000_0000, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1'b0, ST_OK,      5'd0},
            '{CMD_DELETE, 32'h0000_0005, 1'b1, ST_MISSING, 5'd5},
            '{CMD_DELETE, 32'h8000_0000, 1'b0, ST_OK,      5'd0},
            '{CMD_DELETE, 32'h7FFF_FFFF, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h5555_5555, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h0000_0001, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hFFFF_FFFE, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h4000_0000, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hC000_0000, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h1234_5678, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hEDCB_A987, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h0000_0001, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h7FFF_FFFE, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h8000_0001, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h0F0F_0F0F, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'hF0F0_F0F0, 1'b0, ST_OK,      5'd0},
            '{CMD_INSERT, 32'h0000_0000, 1'b1, ST_FULL,    5'd16},
            '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_FULL,    5'd16},
            '{CMD_DELETE, 32'h7FFF_FFFF, 1'b1, ST_OK,      5'd15}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            typed_res.status = directed_rows[i].status;
            typed_res.count  = directed_rows[i].count;
            send_word(directed_rows[i].cmd, directed_rows[i].k,
                      directed_rows[i].typed, typed_res);
        end

        // fill, drain and mixed phases swing the count between empty and full
        ins_pct = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 15;
                    default: ins_pct = 50;
                endcase
            end
            cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
            if (cmd == CMD_DELETE && held_cnt > 0 && $urandom_range(0, 99) < 70)
                k = held_keys[$urandom_range(0, held_cnt - 1)];
            else
                k = random_key();
            send_word(cmd, k, 1'b0, typed_res);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sorted_descending_key_table_top.f =====
sv/sdkt_pkg.sv
sv/sdkt_cell.sv
sv/sorted_descending_key_table_top.sv
tb/tb.sv
